[hdl/byte_ring_buffer_defines.svh]
// ----------------------------------------------------------------------------
// byte_ring_buffer_defines
// Assertion macros shared by the byte ring buffer modules.
// ----------------------------------------------------------------------------
`ifndef BYTE_RING_BUFFER_DEFINES_SVH
`define BYTE_RING_BUFFER_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define BRB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("byte ring buffer assertion failed");

// next-cycle implication
`define BRB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("byte ring buffer assertion failed");

`else

`define BRB_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BRB_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[hdl/brb_pkg.sv]
// ----------------------------------------------------------------------------
// brb_pkg
// Shared widths, command codes and controller/datapath types.
// ----------------------------------------------------------------------------
`default_nettype none

package brb_pkg;

  localparam int unsigned DEPTH_DEF     = 1024;
  localparam int unsigned MAX_BURST_DEF = 64;

  localparam int unsigned CMD_W     = 2;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned COUNT_W   = 7;
  localparam int unsigned CNT_OUT_W = 10;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE   = 2'd0,
    CMD_DEQUEUE = 2'd1,
    CMD_PEEK    = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_e;

  typedef struct packed {
    logic accept;
    logic fetch;
    logic load_byte;
    logic load_resp;
  } ctl_t;

  typedef struct packed {
    logic n_zero;
    logic last_byte;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

[hdl/brb_in_if.sv]
// ----------------------------------------------------------------------------
// brb_in_if
// Command channel: valid/ready with command, data byte and count.
// ----------------------------------------------------------------------------
`default_nettype none

interface brb_in_if;
  logic                           valid;
  logic                           ready;
  logic [brb_pkg::CMD_W-1:0]      cmd;
  logic [brb_pkg::BYTE_W-1:0]     data_byte;
  logic [brb_pkg::COUNT_W-1:0]    count;

  modport source (output valid, output cmd, output data_byte, output count, input ready);
  modport sink   (input valid, input cmd, input data_byte, input count, output ready);
endinterface

`default_nettype wire

[hdl/brb_out_if.sv]
// ----------------------------------------------------------------------------
// brb_out_if
// Result channel: valid/ready with byte, flags and fill counts.
// ----------------------------------------------------------------------------
`default_nettype none

interface brb_out_if;
  logic                            valid;
  logic                            ready;
  logic [brb_pkg::BYTE_W-1:0]      out_byte;
  logic                            byte_valid;
  logic                            last;
  logic                            accepted;
  logic [brb_pkg::CNT_OUT_W-1:0]   used_count;
  logic [brb_pkg::CNT_OUT_W-1:0]   free_count;

  modport source (output valid, output out_byte, output byte_valid, output last,
                  output accepted, output used_count, output free_count, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input last,
                  input accepted, input used_count, input free_count, output ready);
endinterface

`default_nettype wire

[hdl/brb_ram.sv]
// ----------------------------------------------------------------------------
// brb_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module brb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hdl/brb_ctrl.sv]
// ----------------------------------------------------------------------------
// brb_ctrl
// Sequencer: accepts a command, steps byte reads, hands results to output.
// ----------------------------------------------------------------------------
`default_nettype none
`include "byte_ring_buffer_defines.svh"

module brb_ctrl (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  input  wire logic [brb_pkg::CMD_W-1:0] cmd_i,
  output logic                           in_ready_o,
  input  wire brb_pkg::sts_t             sts_i,
  output brb_pkg::ctl_t                  ctl_o
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FETCH = 4'b0010,
    S_LOAD  = 4'b0100,
    S_RESP  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   is_read;

  assign in_ready_o = (state_q == S_IDLE);
  assign is_read    = (cmd_i == brb_pkg::CMD_DEQUEUE) || (cmd_i == brb_pkg::CMD_PEEK);

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.accept = 1'b1;
          state_d      = (is_read && !sts_i.n_zero) ? S_FETCH : S_RESP;
        end
      end
      S_FETCH: begin
        ctl_o.fetch = 1'b1;
        state_d     = S_LOAD;
      end
      S_LOAD: begin
        if (sts_i.out_free) begin
          ctl_o.load_byte = 1'b1;
          state_d         = sts_i.last_byte ? S_IDLE : S_FETCH;
        end
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          ctl_o.load_resp = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `BRB_ASSERT_NEXT(a_fetch_then_load, clk_i, rst_ni, state_q == S_FETCH, state_q == S_LOAD)
  `BRB_ASSERT_NEXT(a_last_byte_ends, clk_i, rst_ni, ctl_o.load_byte && sts_i.last_byte, state_q == S_IDLE)
  `BRB_ASSERT_IMPL(a_accept_in_idle, clk_i, rst_ni, ctl_o.accept, state_q == S_IDLE)

endmodule

`default_nettype wire

[hdl/brb_dpath.sv]
// ----------------------------------------------------------------------------
// brb_dpath
// Pointers, fill counts, byte store and the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "byte_ring_buffer_defines.svh"

module brb_dpath #(
  parameter int unsigned DEPTH     = brb_pkg::DEPTH_DEF,
  parameter int unsigned MAX_BURST = brb_pkg::MAX_BURST_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire brb_pkg::ctl_t                 ctl_i,
  input  wire logic [brb_pkg::CMD_W-1:0]     cmd_i,
  input  wire logic [brb_pkg::BYTE_W-1:0]    data_byte_i,
  input  wire logic [brb_pkg::COUNT_W-1:0]   count_i,
  output brb_pkg::sts_t                      sts_o,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output logic [brb_pkg::BYTE_W-1:0]         out_byte_o,
  output logic                               byte_valid_o,
  output logic                               last_o,
  output logic                               accepted_o,
  output logic [brb_pkg::CNT_OUT_W-1:0]      used_count_o,
  output logic [brb_pkg::CNT_OUT_W-1:0]      free_count_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned SW = AW + 1;
  localparam int unsigned XW = ((AW > brb_pkg::COUNT_W) ? AW : brb_pkg::COUNT_W) + 1;
  localparam int unsigned OW = brb_pkg::CNT_OUT_W;

  localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [XW-1:0] BURST_X  = XW'(MAX_BURST);

  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AW-1:0] scan_q, scan_d;
  logic [brb_pkg::COUNT_W-1:0] remain_q, remain_d;
  logic acc_q, acc_d;

  logic out_valid_q, out_valid_d;
  logic [brb_pkg::BYTE_W-1:0] out_byte_q;
  logic byte_valid_q, last_q, accepted_q;
  logic [OW-1:0] used_out_q, free_out_q;

  logic [AW-1:0] used, free_cnt;
  logic          full;
  logic [XW-1:0] count_x, used_x, req_x, n_x;
  logic [brb_pkg::COUNT_W-1:0] n;
  logic [SW-1:0] rd_sum, rd_adv;
  logic [AW-1:0] wr_inc, scan_inc;
  logic [AW+OW-1:0] used_ext, free_ext;
  logic          is_write, ram_we;
  logic [brb_pkg::BYTE_W-1:0] ram_rdata;
  logic          out_free;

  always_comb begin
    if (wr_ptr_q >= rd_ptr_q) begin
      used = wr_ptr_q - rd_ptr_q;
    end else begin
      used = AW'({1'b0, wr_ptr_q} + DEPTH_S - {1'b0, rd_ptr_q});
    end
  end

  assign free_cnt = LAST_IDX - used;
  assign full     = (used == LAST_IDX);
  assign is_write = (cmd_i == brb_pkg::CMD_WRITE);

  assign count_x = XW'(count_i);
  assign used_x  = XW'(used);
  assign req_x   = (count_x > BURST_X) ? BURST_X : count_x;
  assign n_x     = (req_x > used_x) ? used_x : req_x;
  assign n       = n_x[brb_pkg::COUNT_W-1:0];

  assign rd_sum   = {1'b0, rd_ptr_q} + SW'(n);
  assign rd_adv   = (rd_sum >= DEPTH_S) ? (rd_sum - DEPTH_S) : rd_sum;
  assign wr_inc   = (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + AW'(1);
  assign scan_inc = (scan_q == LAST_IDX) ? '0 : scan_q + AW'(1);

  assign ram_we = ctl_i.accept && is_write && !full;

  always_comb begin
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    scan_d   = scan_q;
    remain_d = remain_q;
    acc_d    = acc_q;
    if (ctl_i.accept) begin
      acc_d = ram_we;
      case (cmd_i)
        brb_pkg::CMD_WRITE: begin
          if (!full) begin
            wr_ptr_d = wr_inc;
          end
        end
        brb_pkg::CMD_DEQUEUE: begin
          scan_d   = rd_ptr_q;
          remain_d = n;
          rd_ptr_d = rd_adv[AW-1:0];
        end
        brb_pkg::CMD_PEEK: begin
          scan_d   = rd_ptr_q;
          remain_d = n;
        end
        brb_pkg::CMD_CLEAR: begin
          rd_ptr_d = '0;
          wr_ptr_d = '0;
        end
        default: begin
          acc_d = 1'b0;
        end
      endcase
    end
    if (ctl_i.fetch) begin
      scan_d   = scan_inc;
      remain_d = remain_q - brb_pkg::COUNT_W'(1);
    end
  end

  brb_ram #(
    .WIDTH (brb_pkg::BYTE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_ptr_q),
    .wdata_i (data_byte_i),
    .re_i    (ctl_i.fetch),
    .raddr_i (scan_q),
    .rdata_o (ram_rdata)
  );

  assign out_free = !out_valid_q || out_ready_i;
  assign used_ext = {{OW{1'b0}}, used};
  assign free_ext = {{OW{1'b0}}, free_cnt};

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (ctl_i.load_byte || ctl_i.load_resp) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rd_ptr_q    <= rd_ptr_d;
      wr_ptr_q    <= wr_ptr_d;
      remain_q    <= remain_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q <= scan_d;
    acc_q  <= acc_d;
    if (ctl_i.load_byte) begin
      out_byte_q   <= ram_rdata;
      byte_valid_q <= 1'b1;
      last_q       <= (remain_q == '0);
      accepted_q   <= 1'b0;
      used_out_q   <= used_ext[OW-1:0];
      free_out_q   <= free_ext[OW-1:0];
    end else if (ctl_i.load_resp) begin
      out_byte_q   <= '0;
      byte_valid_q <= 1'b0;
      last_q       <= 1'b1;
      accepted_q   <= acc_q;
      used_out_q   <= used_ext[OW-1:0];
      free_out_q   <= free_ext[OW-1:0];
    end
  end

  assign sts_o.n_zero    = (n == '0);
  assign sts_o.last_byte = (remain_q == '0);
  assign sts_o.out_free  = out_free;

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign byte_valid_o = byte_valid_q;
  assign last_o       = last_q;
  assign accepted_o   = accepted_q;
  assign used_count_o = used_out_q;
  assign free_count_o = free_out_q;

  `BRB_ASSERT_IMPL(a_load_into_free, clk_i, rst_ni, ctl_i.load_byte || ctl_i.load_resp, out_free)
  `BRB_ASSERT_IMPL(a_fetch_has_work, clk_i, rst_ni, ctl_i.fetch, remain_q != '0)
  `BRB_ASSERT_IMPL(a_ptrs_in_range, clk_i, rst_ni, 1'b1, ({1'b0, rd_ptr_q} < DEPTH_S) && ({1'b0, wr_ptr_q} < DEPTH_S))

endmodule

`default_nettype wire

[hdl/byte_ring_buffer.sv]
// ----------------------------------------------------------------------------
// byte_ring_buffer
// Circular byte FIFO with write, dequeue, peek and clear commands.
//
//   port    dir   beat contents
//   in_i    in    cmd, data_byte, count
//   out_o   out   out_byte, byte_valid, last, accepted, used_count, free_count
//
// Write, clear and empty reads: the accept cycle, then a step that loads the
// result into the output register.
// Dequeue and peek: the accept cycle, then a fetch step and a load step per
// byte, as the byte store read is registered; a burst is min(count, used, MAX_BURST) beats.
// A new command is taken once the previous one has handed its last beat to
// the output register. Output stalls hold the sequencer in its load step.
// Reset clears both pointers; the byte store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_ring_buffer #(
  parameter int unsigned DEPTH     = brb_pkg::DEPTH_DEF,
  parameter int unsigned MAX_BURST = brb_pkg::MAX_BURST_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  brb_in_if.sink     in_i,
  brb_out_if.source  out_o
);

  brb_pkg::ctl_t ctl;
  brb_pkg::sts_t sts;

  brb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .cmd_i      (in_i.cmd),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  brb_dpath #(
    .DEPTH     (DEPTH),
    .MAX_BURST (MAX_BURST)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .cmd_i        (in_i.cmd),
    .data_byte_i  (in_i.data_byte),
    .count_i      (in_i.count),
    .sts_o        (sts),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .out_byte_o   (out_o.out_byte),
    .byte_valid_o (out_o.byte_valid),
    .last_o       (out_o.last),
    .accepted_o   (out_o.accepted),
    .used_count_o (out_o.used_count),
    .free_count_o (out_o.free_count)
  );

endmodule

`default_nettype wire

[tb/byte_ring_buffer_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_ring_buffer_tb
// Self-checking bench for the circular byte FIFO. A clocked driver feeds
// write, dequeue, peek and clear commands from a queue. A ring model
// predicts every result beat. A clocked monitor checks each beat field by
// field. Runs a directed opener and random traffic under three idle mixes,
// with one long output hold-off.
// ----------------------------------------------------------------------------

module byte_ring_buffer_tb;

  localparam int unsigned DEPTH         = brb_pkg::DEPTH_DEF;
  localparam int unsigned MAX_BURST     = brb_pkg::MAX_BURST_DEF;
  localparam int unsigned CW            = brb_pkg::CNT_OUT_W;
  localparam int unsigned CYCLE_LIMIT   = 400_000;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned HOLD_CYCLES   = 300;

  typedef struct packed {
    brb_pkg::cmd_e                 cmd;
    logic [brb_pkg::BYTE_W-1:0]    data_byte;
    logic [brb_pkg::COUNT_W-1:0]   count;
  } cmd_item_t;

  typedef struct packed {
    logic [brb_pkg::BYTE_W-1:0]    out_byte;
    logic                          byte_valid;
    logic                          last;
    logic                          accepted;
    logic [CW-1:0]                 used_count;
    logic [CW-1:0]                 free_count;
  } beat_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b1;

  brb_in_if  cmd_if ();
  brb_out_if beat_if ();

  byte_ring_buffer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (beat_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  cmd_item_t          pending_cmds[$];
  cmd_item_t          on_bus;
  beat_t              expected_beats[$];

  logic [brb_pkg::BYTE_W-1:0] ring_store [DEPTH];
  int unsigned        rd_ptr = 0;
  int unsigned        wr_ptr = 0;

  int unsigned        tx_idle_pct = 0;
  int unsigned        rx_idle_pct = 0;
  logic               hold_go     = 1'b0;
  logic               hold_off    = 1'b0;

  int unsigned        cmds_queued = 0;
  int unsigned        cmds_taken  = 0;
  int unsigned        cycle_cnt   = 0;
  int unsigned        fail_cnt    = 0;
  int unsigned        beats_seen  = 0;
  int unsigned        n_writes    = 0;
  int unsigned        n_drops     = 0;
  int unsigned        n_dequeues  = 0;
  int unsigned        n_peeks     = 0;
  int unsigned        n_clears    = 0;
  int unsigned        n_empty_rd  = 0;
  int unsigned        n_saturated = 0;
  int unsigned        n_wraps     = 0;

  function automatic int unsigned ring_used();
    return (wr_ptr + DEPTH - rd_ptr) % DEPTH;
  endfunction

  function automatic int unsigned ring_next(input int unsigned ptr);
    if (ptr == DEPTH - 1) begin
      n_wraps++;
      return 0;
    end
    return ptr + 1;
  endfunction

  function automatic void push_beat(input logic [brb_pkg::BYTE_W-1:0] b, input logic bv,
                                    input logic lst, input logic acc);
    beat_t bt;
    int unsigned used;
    used          = ring_used();
    bt.out_byte   = b;
    bt.byte_valid = bv;
    bt.last       = lst;
    bt.accepted   = acc;
    bt.used_count = CW'(used);
    bt.free_count = CW'(DEPTH - 1 - used);
    expected_beats.push_back(bt);
  endfunction

  function automatic void predict_cmd(input cmd_item_t it);
    logic [brb_pkg::BYTE_W-1:0] burst [MAX_BURST];
    int unsigned n;
    int unsigned idx;
    logic acc;
    case (it.cmd)
      brb_pkg::CMD_WRITE: begin
        n_writes++;
        acc = 1'b0;
        if (ring_used() < DEPTH - 1) begin
          ring_store[wr_ptr] = it.data_byte;
          wr_ptr = ring_next(wr_ptr);
          acc = 1'b1;
        end else begin
          n_drops++;
        end
        push_beat('0, 1'b0, 1'b1, acc);
      end
      brb_pkg::CMD_CLEAR: begin
        n_clears++;
        rd_ptr = 0;
        wr_ptr = 0;
        push_beat('0, 1'b0, 1'b1, 1'b0);
      end
      default: begin
        if (it.cmd == brb_pkg::CMD_DEQUEUE) n_dequeues++;
        else n_peeks++;
        n = 32'(it.count);
        if (n > MAX_BURST) begin
          n = MAX_BURST;
          n_saturated++;
        end
        if (n > ring_used()) n = ring_used();
        idx = rd_ptr;
        for (int i = 0; i < n; i++) begin
          burst[i] = ring_store[idx];
          idx = (it.cmd == brb_pkg::CMD_DEQUEUE) ? ring_next(idx) : (idx + 1) % DEPTH;
        end
        if (it.cmd == brb_pkg::CMD_DEQUEUE) rd_ptr = idx;
        if (n == 0) begin
          n_empty_rd++;
          push_beat('0, 1'b0, 1'b1, 1'b0);
        end else begin
          for (int i = 0; i < n; i++) push_beat(burst[i], 1'b1, i == n - 1, 1'b0);
        end
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [CW-1:0] exp_v,
                                      input logic [CW-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_cnt++;
    end
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_if.valid     <= 1'b0;
      cmd_if.cmd       <= brb_pkg::CMD_WRITE;
      cmd_if.data_byte <= '0;
      cmd_if.count     <= '0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        predict_cmd(on_bus);
        cmds_taken++;
      end
      if (!cmd_if.valid || cmd_if.ready) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          on_bus = pending_cmds.pop_front();
          cmd_if.valid     <= 1'b1;
          cmd_if.cmd       <= on_bus.cmd;
          cmd_if.data_byte <= on_bus.data_byte;
          cmd_if.count     <= on_bus.count;
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    beat_t exp_b;
    if (!rst_ni) begin
      beat_if.ready <= 1'b0;
    end else begin
      if (beat_if.valid && beat_if.ready) begin
        beats_seen++;
        if (expected_beats.size() == 0) begin
          $error("unexpected result beat: out_byte %0d last %0b", beat_if.out_byte,
                 beat_if.last);
          fail_cnt++;
        end else begin
          exp_b = expected_beats.pop_front();
          check_field("out_byte",   CW'(exp_b.out_byte),   CW'(beat_if.out_byte));
          check_field("byte_valid", CW'(exp_b.byte_valid), CW'(beat_if.byte_valid));
          check_field("last",       CW'(exp_b.last),       CW'(beat_if.last));
          check_field("accepted",   CW'(exp_b.accepted),   CW'(beat_if.accepted));
          check_field("used_count", exp_b.used_count,      beat_if.used_count);
          check_field("free_count", exp_b.free_count,      beat_if.free_count);
        end
      end
      beat_if.ready <= !hold_off && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // long output hold-off while commands keep coming
  initial begin
    wait (hold_go);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("byte_ring_buffer verification failed");
      $finish;
    end
  end

  task automatic queue_cmd(input brb_pkg::cmd_e c, input logic [brb_pkg::BYTE_W-1:0] b,
                           input logic [brb_pkg::COUNT_W-1:0] n);
    cmd_item_t it;
    it.cmd       = c;
    it.data_byte = b;
    it.count     = n;
    pending_cmds.push_back(it);
    cmds_queued++;
  endtask

  task automatic queue_random_mix(input int unsigned items);
    int unsigned done;
    int unsigned r;
    int unsigned k;
    logic [brb_pkg::COUNT_W-1:0] n;
    brb_pkg::cmd_e c;
    done = 0;
    while (done < items) begin
      r = $urandom_range(99);
      if (r < 4) begin
        queue_cmd(brb_pkg::CMD_CLEAR, 8'($urandom_range(255)), 7'($urandom_range(127)));
        done++;
      end else if (r < 55) begin
        k = $urandom_range(12, 1);
        repeat (k) begin
          queue_cmd(brb_pkg::CMD_WRITE, 8'($urandom_range(255)), 7'($urandom_range(127)));
        end
        done += k;
      end else begin
        r = $urandom_range(99);
        if (r < 60) n = 7'($urandom_range(8));
        else if (r < 85) n = 7'($urandom_range(64, 9));
        else n = 7'($urandom_range(127, 65));
        c = ($urandom_range(1) != 0) ? brb_pkg::CMD_DEQUEUE : brb_pkg::CMD_PEEK;
        queue_cmd(c, 8'($urandom_range(255)), n);
        done++;
      end
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (cmds_taken != cmds_queued || expected_beats.size() != 0);
  endtask

  initial begin
    rst_ni <= 1'b0;
    tx_idle_pct = 7;
    rx_idle_pct = 61;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty reads, byte extremes, zero and saturated counts, clear
    queue_cmd(brb_pkg::CMD_DEQUEUE, 8'h00, 7'd0);
    queue_cmd(brb_pkg::CMD_PEEK,    8'hFF, 7'd127);
    queue_cmd(brb_pkg::CMD_WRITE,   8'h00, 7'd0);
    queue_cmd(brb_pkg::CMD_WRITE,   8'hFF, 7'd127);
    queue_cmd(brb_pkg::CMD_WRITE,   8'hA5, 7'd0);
    queue_cmd(brb_pkg::CMD_WRITE,   8'h5A, 7'd0);
    queue_cmd(brb_pkg::CMD_PEEK,    8'h00, 7'd0);
    queue_cmd(brb_pkg::CMD_PEEK,    8'h00, 7'd2);
    queue_cmd(brb_pkg::CMD_DEQUEUE, 8'h00, 7'd1);
    queue_cmd(brb_pkg::CMD_DEQUEUE, 8'h00, 7'd127);
    queue_cmd(brb_pkg::CMD_DEQUEUE, 8'h00, 7'd1);
    repeat (5) queue_cmd(brb_pkg::CMD_WRITE, 8'($urandom_range(255)), 7'd0);
    queue_cmd(brb_pkg::CMD_CLEAR,   8'hFF, 7'd127);
    queue_cmd(brb_pkg::CMD_DEQUEUE, 8'h00, 7'd64);
    queue_cmd(brb_pkg::CMD_WRITE,   8'h3C, 7'd0);
    queue_cmd(brb_pkg::CMD_PEEK,    8'h00, 7'd64);
    queue_cmd(brb_pkg::CMD_DEQUEUE, 8'h00, 7'd65);
    queue_random_mix(30);
    wait_drained();

    // short fill and drain with the sender mostly idle
    tx_idle_pct = 61;
    rx_idle_pct = 7;
    queue_cmd(brb_pkg::CMD_CLEAR, 8'h00, 7'd0);
    repeat (12) queue_cmd(brb_pkg::CMD_WRITE, 8'($urandom_range(255)), 7'd0);
    queue_cmd(brb_pkg::CMD_PEEK, 8'h00, 7'd10);
    queue_cmd(brb_pkg::CMD_DEQUEUE, 8'h00, 7'd10);
    queue_random_mix(25);
    wait_drained();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_go = 1'b1;
    repeat (8) queue_cmd(brb_pkg::CMD_WRITE, 8'($urandom_range(255)), 7'd0);
    queue_random_mix(25);
    wait_drained();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_beats.size() != 0) begin
      $error("%0d expected beats never arrived", expected_beats.size());
      fail_cnt++;
    end

    $display("run: %0d commands (%0d writes, %0d dropped at full, %0d dequeues,",
             cmds_taken, n_writes, n_drops, n_dequeues);
    $display("run: %0d peeks, %0d clears), %0d beats checked, %0d empty reads,",
             n_peeks, n_clears, beats_seen, n_empty_rd);
    $display("run: %0d saturated bursts, %0d pointer wraps, %0d errors",
             n_saturated, n_wraps, fail_cnt);
    if (fail_cnt == 0) begin
      $display("byte_ring_buffer verification clean");
    end else begin
      $display("byte_ring_buffer verification failed");
    end
    $finish;
  end

endmodule
